// ===== rtl/bsb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bsb_pkg;

  localparam int COORD_WIDTH_DEFAULT = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int DIM_W       = 16;
  localparam int CHAN_W      = 8;
  localparam int PRESS_W     = 9;
  localparam int NUM_W       = 16;
  localparam int SUM_W       = 24;

  // full opacity: 256 * 255
  localparam logic [NUM_W-1:0]   OPACITY_ONE = 16'd65280;
  localparam logic [PRESS_W-1:0] PRESS_FULL  = 9'd256;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PAINT_COLOR  = 3'd0,
    REG_PRESSURE     = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_DEPTH_MODE   = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_BLEND   = 2'd0,
    MODE_DEPTH32 = 2'd1,
    MODE_UNSUP   = 2'd2
  } depth_mode_t;

  typedef struct packed {
    logic [23:0]        paint_color;
    logic [PRESS_W-1:0] pressure;
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic [1:0]         depth_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    paint_color:  24'd0,
    pressure:     PRESS_FULL,
    image_width:  16'd0,
    image_height: 16'd0,
    depth_mode:   MODE_BLEND
  };

  // advance enables of the multiply and divide stages
  typedef struct packed {
    logic mul;
    logic div;
  } stage_en_t;

endpackage

`default_nettype wire

// ===== rtl/bsb_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsb_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bsb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [bsb_pkg::CFG_DATA_W-1:0]    cfg_data,
  output bsb_pkg::cfg_t                          cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= bsb_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        bsb_pkg::REG_PAINT_COLOR:  cfg.paint_color  <= cfg_data;
        bsb_pkg::REG_PRESSURE:     cfg.pressure     <= cfg_data[bsb_pkg::PRESS_W-1:0];
        bsb_pkg::REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[bsb_pkg::DIM_W-1:0];
        bsb_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[bsb_pkg::DIM_W-1:0];
        bsb_pkg::REG_DEPTH_MODE:   cfg.depth_mode   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bsb_channel.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsb_channel (
  input  wire logic                          clk,
  input  wire bsb_pkg::stage_en_t            en,
  input  wire logic [bsb_pkg::CHAN_W-1:0]    paint,
  input  wire logic [bsb_pkg::CHAN_W-1:0]    old,
  input  wire logic [bsb_pkg::NUM_W-1:0]     num,
  input  wire logic                          blend,
  output logic      [bsb_pkg::CHAN_W-1:0]    result
);

  logic [bsb_pkg::SUM_W-1:0]  sum;
  logic [bsb_pkg::CHAN_W-1:0] old_d;
  logic                       blend_d;

  logic [bsb_pkg::NUM_W-1:0]  t;
  logic [bsb_pkg::CHAN_W-1:0] q;
  logic [bsb_pkg::CHAN_W:0]   rem;
  logic [bsb_pkg::CHAN_W-1:0] quot;

  always_ff @(posedge clk) begin
    if (en.mul) begin
      sum <= bsb_pkg::SUM_W'(paint) * bsb_pkg::SUM_W'(num)
           + bsb_pkg::SUM_W'(old) * bsb_pkg::SUM_W'(bsb_pkg::OPACITY_ONE - num);
      old_d   <= old;
      blend_d <= blend;
    end
  end

  // sum / 65280 = (sum >> 8) / 255; estimate by >> 8, then one correction
  always_comb begin
    t    = sum[bsb_pkg::SUM_W-1:8];
    q    = t[bsb_pkg::NUM_W-1:8];
    rem  = {1'b0, t[7:0]} + {1'b0, q};
    quot = (rem >= 9'd255) ? q + 8'd1 : q;
  end

  always_ff @(posedge clk) begin
    if (en.div) begin
      result <= blend_d ? quot : old_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/brush_stamp_pixel_blend.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Depth-masked brush stamp blend, one pixel per item. A pixel inside the
// image (0 <= x < width, 0 <= y < height) whose brush value exceeds its
// stored depth is written: in 24-bit mode each color channel blends toward
// the paint color by pressure * (brush - depth) / 255, truncated; other modes
// only take the brush value as new depth, and unsupported modes flag
// mode_error. Pressure above 1.0 saturates. The block takes one item every
// cycle unless the output stalls, and returns its result through a
// four-stage pipeline (clip, opacity multiply, channel multiply, divide by
// 65280); each stage advances on its own, so bubbles close up while the
// output stalls. Write configuration only while no item is in flight.
module brush_stamp_pixel_blend #(
  parameter int COORD_WIDTH = bsb_pkg::COORD_WIDTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,

  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bsb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [bsb_pkg::CFG_DATA_W-1:0]    cfg_data,

  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [COORD_WIDTH-1:0]     pixel_x,
  input  wire logic signed [COORD_WIDTH-1:0]     pixel_y,
  input  wire logic [7:0]                        brush_value,
  input  wire logic [7:0]                        depth_in,
  input  wire logic [7:0]                        old_red,
  input  wire logic [7:0]                        old_green,
  input  wire logic [7:0]                        old_blue,

  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   write_pixel,
  output logic [7:0]                             new_red,
  output logic [7:0]                             new_green,
  output logic [7:0]                             new_blue,
  output logic [7:0]                             depth_out,
  output logic                                   mode_error
);

  localparam int CMP_W = ((COORD_WIDTH > bsb_pkg::DIM_W) ? COORD_WIDTH : bsb_pkg::DIM_W) + 1;

  bsb_pkg::cfg_t      cfg;
  bsb_pkg::stage_en_t ch_en;

  logic en1, en2, en3, en4;
  logic v1, v2, v3;

  // stage 1: clip and depth test
  logic [CMP_W-1:0]             x_ext, y_ext, w_ext, h_ext;
  logic                         in_image, hit;
  logic                         wr1;
  logic [7:0]                   diff1, dout1;
  logic [bsb_pkg::PRESS_W-1:0]  psat1;
  logic [7:0]                   r1, g1, b1;

  // stage 2: opacity
  logic                         wr2;
  logic [bsb_pkg::NUM_W-1:0]    num2;
  logic [7:0]                   dout2, r2, g2, b2;

  // stage 3: channel multiply (color path lives in the channel units)
  logic                         wr3, err3;
  logic [7:0]                   dout3;
  logic                         blend2, err2;

  assign en4      = !out_valid || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign ch_en    = '{mul: en3, div: en4};

  bsb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_comb begin
    x_ext    = {{(CMP_W-COORD_WIDTH){1'b0}}, pixel_x};
    y_ext    = {{(CMP_W-COORD_WIDTH){1'b0}}, pixel_y};
    w_ext    = {{(CMP_W-bsb_pkg::DIM_W){1'b0}}, cfg.image_width};
    h_ext    = {{(CMP_W-bsb_pkg::DIM_W){1'b0}}, cfg.image_height};
    in_image = !pixel_x[COORD_WIDTH-1] && !pixel_y[COORD_WIDTH-1]
            && (x_ext < w_ext) && (y_ext < h_ext);
    hit      = brush_value > depth_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      wr1   <= in_image && hit;
      diff1 <= brush_value - depth_in;
      dout1 <= (in_image && hit) ? brush_value : depth_in;
      psat1 <= cfg.pressure[bsb_pkg::PRESS_W-1] ? bsb_pkg::PRESS_FULL : cfg.pressure;
      r1    <= old_red;
      g1    <= old_green;
      b1    <= old_blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      wr2   <= wr1;
      num2  <= bsb_pkg::NUM_W'(psat1 * diff1);
      dout2 <= dout1;
      r2    <= r1;
      g2    <= g1;
      b2    <= b1;
    end
  end

  always_comb begin
    blend2 = wr2 && (cfg.depth_mode == bsb_pkg::MODE_BLEND);
    err2   = wr2 && (cfg.depth_mode != bsb_pkg::MODE_BLEND)
                 && (cfg.depth_mode != bsb_pkg::MODE_DEPTH32);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      wr3   <= wr2;
      err3  <= err2;
      dout3 <= dout2;
    end
  end

  bsb_channel u_red (
    .clk    (clk),
    .en     (ch_en),
    .paint  (cfg.paint_color[23:16]),
    .old    (r2),
    .num    (num2),
    .blend  (blend2),
    .result (new_red)
  );

  bsb_channel u_green (
    .clk    (clk),
    .en     (ch_en),
    .paint  (cfg.paint_color[15:8]),
    .old    (g2),
    .num    (num2),
    .blend  (blend2),
    .result (new_green)
  );

  bsb_channel u_blue (
    .clk    (clk),
    .en     (ch_en),
    .paint  (cfg.paint_color[7:0]),
    .old    (b2),
    .num    (num2),
    .blend  (blend2),
    .result (new_blue)
  );

  // stage 4: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en4) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      write_pixel <= wr3;
      mode_error  <= err3;
      depth_out   <= dout3;
    end
  end

`ifndef SYNTH
  a_err_implies_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode_error |-> write_pixel)
    else $error("mode_error without write_pixel");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted item not in first stage");

  a_opacity_bound: assert property (@(posedge clk) disable iff (rst)
    v2 |-> num2 <= bsb_pkg::OPACITY_ONE)
    else $error("opacity numerator above full scale");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v3 && !en3 |=> v3 && $stable(dout3))
    else $error("stage three lost its item under stall");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_brush_stamp_pixel_blend.sv =====
`timescale 1ns / 1ps

module tb_brush_stamp_pixel_blend;
  import bsb_pkg::*;

  localparam int CW = COORD_WIDTH_DEFAULT;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] MODE_UNDEF = 2'd3;

  typedef enum logic [2:0] {
    ENT_PIXEL,
    ENT_REG,
    ENT_DRAIN,
    ENT_PHASE,
    ENT_HOLD
  } plan_kind_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [7:0]           brush;
    logic [7:0]           depth;
    logic [7:0]           r;
    logic [7:0]           g;
    logic [7:0]           b;
  } stamp_pixel_t;

  typedef struct packed {
    logic       wr;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] depth;
    logic       err;
  } blended_pixel_t;

  typedef struct packed {
    plan_kind_t   kind;
    stamp_pixel_t pix;
    reg_index_t   idx;
    logic [23:0]  data;
    logic [6:0]   tx_pct;
    logic [6:0]   rx_pct;
  } plan_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  reg_index_t   cur_idx = REG_PAINT_COLOR;
  logic [23:0]  cur_data = '0;

  logic         in_valid = 1'b0;
  logic         in_ready;
  stamp_pixel_t cur_pix = '0;

  logic         out_valid;
  logic         out_ready = 1'b0;
  logic         write_pixel;
  logic [7:0]   new_red;
  logic [7:0]   new_green;
  logic [7:0]   new_blue;
  logic [7:0]   depth_out;
  logic         mode_error;

  // shadow copy of the configuration registers
  logic [23:0]  mdl_color    = CFG_RESET.paint_color;
  logic [8:0]   mdl_pressure = CFG_RESET.pressure;
  logic [15:0]  mdl_width    = CFG_RESET.image_width;
  logic [15:0]  mdl_height   = CFG_RESET.image_height;
  logic [1:0]   mdl_mode     = CFG_RESET.depth_mode;

  plan_entry_t    pixel_plan[$];
  blended_pixel_t blended_q[$];

  int tx_pct = 0;
  int rx_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int err_count = 0;
  int n_pixels = 0;
  int n_results = 0;
  int n_written = 0;
  int n_flagged = 0;
  int n_regs = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  brush_stamp_pixel_blend #(.COORD_WIDTH(CW)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cur_idx),
    .cfg_data   (cur_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_x    (cur_pix.x),
    .pixel_y    (cur_pix.y),
    .brush_value(cur_pix.brush),
    .depth_in   (cur_pix.depth),
    .old_red    (cur_pix.r),
    .old_green  (cur_pix.g),
    .old_blue   (cur_pix.b),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .write_pixel(write_pixel),
    .new_red    (new_red),
    .new_green  (new_green),
    .new_blue   (new_blue),
    .depth_out  (depth_out),
    .mode_error (mode_error)
  );

  function automatic logic [7:0] mix_channel(logic [7:0] c, logic [7:0] o, int unsigned num);
    int unsigned acc;
    acc = (c * num + o * (32'(OPACITY_ONE) - num)) / 32'(OPACITY_ONE);
    return acc[7:0];
  endfunction

  function automatic blended_pixel_t blend_pixel(stamp_pixel_t it);
    blended_pixel_t res;
    int xi;
    int yi;
    int unsigned p;
    int unsigned num;
    logic in_image;
    xi = $signed(it.x);
    yi = $signed(it.y);
    in_image = xi >= 0 && xi < int'({16'd0, mdl_width}) &&
               yi >= 0 && yi < int'({16'd0, mdl_height});
    res.wr = 1'b0;
    res.r = it.r;
    res.g = it.g;
    res.b = it.b;
    res.depth = it.depth;
    res.err = 1'b0;
    if (in_image && it.brush > it.depth) begin
      // saturate pressure at 1.0
      p = (mdl_pressure > PRESS_FULL) ? 32'(PRESS_FULL) : 32'(mdl_pressure);
      num = p * (32'(it.brush) - 32'(it.depth));
      res.wr = 1'b1;
      res.depth = it.brush;
      if (mdl_mode == MODE_BLEND) begin
        res.r = mix_channel(mdl_color[23:16], it.r, num);
        res.g = mix_channel(mdl_color[15:8], it.g, num);
        res.b = mix_channel(mdl_color[7:0], it.b, num);
      end else if (mdl_mode != MODE_DEPTH32) begin
        res.err = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic add_pixel(int x, int y, int br, int dp, int r, int g, int b);
    plan_entry_t e;
    e = '0;
    e.kind = ENT_PIXEL;
    e.pix.x = x[CW-1:0];
    e.pix.y = y[CW-1:0];
    e.pix.brush = br[7:0];
    e.pix.depth = dp[7:0];
    e.pix.r = r[7:0];
    e.pix.g = g[7:0];
    e.pix.b = b[7:0];
    pixel_plan.push_back(e);
  endtask

  task automatic add_marker(plan_kind_t kind, int tx, int rx);
    plan_entry_t e;
    e = '0;
    e.kind = kind;
    e.tx_pct = tx[6:0];
    e.rx_pct = rx[6:0];
    pixel_plan.push_back(e);
  endtask

  // drain the pipeline before every register write
  task automatic add_reg(reg_index_t idx, logic [23:0] data);
    plan_entry_t e;
    add_marker(ENT_DRAIN, 0, 0);
    e = '0;
    e.kind = ENT_REG;
    e.idx = idx;
    e.data = data;
    pixel_plan.push_back(e);
  endtask

  always @(posedge clk) begin : drive
    plan_entry_t head;
    logic nxt_in;
    logic nxt_cfg;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nxt_in = in_valid && !in_ready;
      nxt_cfg = cfg_valid && !cfg_ready;
      if (in_valid && in_ready) begin
        blended_q.push_back(blend_pixel(cur_pix));
        n_pixels++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cur_idx)
          REG_PAINT_COLOR:  mdl_color = cur_data;
          REG_PRESSURE:     mdl_pressure = cur_data[8:0];
          REG_IMAGE_WIDTH:  mdl_width = cur_data[15:0];
          REG_IMAGE_HEIGHT: mdl_height = cur_data[15:0];
          REG_DEPTH_MODE:   mdl_mode = cur_data[1:0];
          default: ;
        endcase
        n_regs++;
      end
      if (!nxt_in && !nxt_cfg && pixel_plan.size() != 0) begin
        head = pixel_plan[0];
        case (head.kind)
          ENT_PIXEL: begin
            if ($urandom_range(99) >= tx_pct) begin
              cur_pix <= head.pix;
              nxt_in = 1'b1;
              void'(pixel_plan.pop_front());
            end
          end
          ENT_REG: begin
            if (blended_q.size() == 0) begin
              cur_idx <= head.idx;
              cur_data <= head.data;
              nxt_cfg = 1'b1;
              void'(pixel_plan.pop_front());
            end
          end
          ENT_DRAIN: begin
            if (blended_q.size() == 0)
              void'(pixel_plan.pop_front());
          end
          ENT_PHASE: begin
            tx_pct = int'(head.tx_pct);
            rx_pct <= int'(head.rx_pct);
            void'(pixel_plan.pop_front());
          end
          ENT_HOLD: begin
            hold_token <= hold_token + 1;
            void'(pixel_plan.pop_front());
          end
          default: void'(pixel_plan.pop_front());
        endcase
      end
      in_valid <= nxt_in;
      cfg_valid <= nxt_cfg;
    end
  end

  always @(posedge clk) begin : monitor
    blended_pixel_t want;
    blended_pixel_t got;
    logic rdy;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        got = '{write_pixel, new_red, new_green, new_blue, depth_out, mode_error};
        if (blended_q.size() == 0) begin
          if (err_count < 10)
            $display("%0t: unexpected result wr=%0d rgb=%02x%02x%02x d=%0d err=%0d",
                     $realtime, got.wr, got.r, got.g, got.b, got.depth, got.err);
          err_count++;
        end else begin
          want = blended_q.pop_front();
          if (want.wr) n_written++;
          if (want.err) n_flagged++;
          if (got.wr !== want.wr || got.r !== want.r || got.g !== want.g ||
              got.b !== want.b || got.depth !== want.depth || got.err !== want.err) begin
            if (err_count < 10)
              $display("%0t: exp %0d %02x%02x%02x %0d %0d, got %0d %02x%02x%02x %0d %0d",
                       $realtime, want.wr, want.r, want.g, want.b, want.depth, want.err,
                       got.wr, got.r, got.g, got.b, got.depth, got.err);
            err_count++;
          end
        end
      end
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        rdy = $urandom_range(99) >= rx_pct;
      end
      out_ready <= rdy;
    end
  end

  initial begin
    int ph;
    int seg;
    int k;
    int w;
    int h;
    int xr;
    int yr;
    int x;
    int y;
    int br;
    int dp;

    add_marker(ENT_PHASE, 16, 51);
    add_reg(REG_IMAGE_WIDTH, 24'd64);
    add_reg(REG_IMAGE_HEIGHT, 24'd32);
    add_reg(REG_PAINT_COLOR, 24'hFF8000);
    add_reg(REG_PRESSURE, 24'(PRESS_FULL));
    add_reg(REG_DEPTH_MODE, 24'(MODE_BLEND));
    // corners, just outside each edge, coordinate extremes
    add_pixel(0, 0, 255, 0, 0, 0, 0);
    add_pixel(63, 31, 200, 100, 255, 255, 255);
    add_pixel(64, 0, 255, 0, 1, 2, 3);
    add_pixel(0, 32, 255, 0, 4, 5, 6);
    add_pixel(-1, 5, 255, 0, 7, 8, 9);
    add_pixel(5, -1, 255, 0, 10, 11, 12);
    add_pixel(-32768, 32767, 255, 0, 13, 14, 15);
    add_pixel(32767, -32768, 255, 0, 16, 17, 18);
    // brush equal to, below, and one above the stored depth
    add_pixel(10, 10, 77, 77, 90, 91, 92);
    add_pixel(10, 10, 0, 255, 93, 94, 95);
    add_pixel(10, 10, 1, 0, 170, 85, 255);
    // pressure above full saturates, then zero pressure, then the other depth modes
    add_reg(REG_PRESSURE, 24'd511);
    add_pixel(3, 3, 255, 0, 10, 20, 30);
    add_reg(REG_PRESSURE, 24'd257);
    add_pixel(3, 3, 128, 0, 200, 100, 50);
    add_reg(REG_PRESSURE, 24'd0);
    add_pixel(3, 3, 255, 0, 40, 50, 60);
    add_reg(REG_PRESSURE, 24'(PRESS_FULL));
    add_reg(REG_DEPTH_MODE, 24'(MODE_DEPTH32));
    add_pixel(4, 4, 200, 10, 1, 2, 3);
    add_pixel(4, 4, 10, 200, 1, 2, 3);
    add_reg(REG_DEPTH_MODE, 24'(MODE_UNSUP));
    add_pixel(4, 4, 200, 10, 1, 2, 3);
    add_pixel(99, 4, 200, 10, 1, 2, 3);
    add_reg(REG_DEPTH_MODE, 24'(MODE_UNDEF));
    add_pixel(4, 4, 201, 10, 1, 2, 3);
    add_reg(REG_DEPTH_MODE, 24'(MODE_BLEND));
    // zero width or height clips everything
    add_reg(REG_IMAGE_WIDTH, 24'd0);
    add_pixel(0, 0, 255, 0, 1, 2, 3);
    add_reg(REG_IMAGE_WIDTH, 24'd65535);
    add_reg(REG_IMAGE_HEIGHT, 24'd0);
    add_pixel(0, 0, 255, 0, 1, 2, 3);
    add_reg(REG_IMAGE_HEIGHT, 24'd65535);
    add_reg(REG_PAINT_COLOR, 24'hFFFFFF);
    add_pixel(32767, 32767, 255, 0, 0, 0, 0);

    for (ph = 0; ph < 3; ph++) begin
      if (ph == 0)
        add_marker(ENT_PHASE, 16, 51);
      else if (ph == 1)
        add_marker(ENT_PHASE, 51, 16);
      else
        add_marker(ENT_PHASE, 0, 0);
      for (seg = 0; seg < 6; seg++) begin
        case ($urandom_range(9))
          0: w = 0;
          1: w = 65535;
          default: w = $urandom_range(1, 120);
        endcase
        case ($urandom_range(9))
          0: h = 0;
          1: h = 65535;
          default: h = $urandom_range(1, 120);
        endcase
        add_reg(REG_IMAGE_WIDTH, w[23:0]);
        add_reg(REG_IMAGE_HEIGHT, h[23:0]);
        case ($urandom_range(5))
          0: add_reg(REG_PAINT_COLOR, 24'h000000);
          1: add_reg(REG_PAINT_COLOR, 24'hFFFFFF);
          default: add_reg(REG_PAINT_COLOR, 24'($urandom));
        endcase
        case ($urandom_range(4))
          0: add_reg(REG_PRESSURE, 24'd0);
          1: add_reg(REG_PRESSURE, 24'(PRESS_FULL));
          2: add_reg(REG_PRESSURE, 24'd511);
          default: add_reg(REG_PRESSURE, 24'($urandom_range(0, 511)));
        endcase
        if ($urandom_range(9) < 6)
          add_reg(REG_DEPTH_MODE, 24'(MODE_BLEND));
        else
          add_reg(REG_DEPTH_MODE, 24'($urandom_range(1, 3)));
        // long output stall while items keep coming
        if (ph == 2 && seg == 2)
          add_marker(ENT_HOLD, 0, 0);
        xr = (w > 200) ? 200 : w;
        yr = (h > 200) ? 200 : h;
        for (k = 0; k < 100; k++) begin
          if ($urandom_range(9) == 0) begin
            x = $urandom;
            y = $urandom;
          end else begin
            x = int'($urandom_range(0, xr + 3)) - 2;
            y = int'($urandom_range(0, yr + 3)) - 2;
          end
          if ($urandom_range(3) != 0) begin
            dp = $urandom_range(0, 254);
            br = $urandom_range(dp + 1, 255);
          end else begin
            dp = $urandom_range(0, 255);
            br = $urandom_range(0, 255);
          end
          add_pixel(x, y, br, dp, $urandom, $urandom, $urandom);
        end
        // hold back the sender until the stalled results have all come out
        if (ph == 2 && seg == 2)
          add_marker(ENT_DRAIN, 0, 0);
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pixel_plan.size() != 0 || in_valid || cfg_valid || blended_q.size() != 0)
      @(negedge clk);
    repeat (12) @(posedge clk);

    $display("covered %0d pixels, %0d results: %0d written, %0d with mode error",
             n_pixels, n_results, n_written, n_flagged);
    $display("across %0d register writes incl. clipping edges, pressure saturation, all modes",
             n_regs);
    if (err_count == 0 && blended_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results still pending", err_count, blended_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d results pending", blended_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
